/* rtl/fsipa_pkg.sv */
`timescale 1ns / 1ps

package fsipa_pkg;

   localparam int NUM_POOLS_DEF = 8;
   localparam int NUM_BLOCKS_DEF = 16;
   localparam int MAX_ITEMS_DEF = 1024;

   localparam int IDX_W = 14;
   localparam int POOL_ID_W = 3;
   localparam int BYTES_W = 17;
   localparam int IPB_W = 11;
   localparam int OFF_W = 30;
   localparam int STATUS_W = 3;
   localparam int CSR_DATA_W = 17;
   localparam int CSR_INDEX_W = 1;
   localparam int PROD_W = IDX_W + BYTES_W;

   localparam int MIN_ITEM_BYTES = 16;
   localparam int MAX_ITEM_BYTES = 65536;
   localparam int RESET_ITEM_BYTES = 16;
   localparam int RESET_IPB = 1024;

   typedef enum logic [STATUS_W-1:0] {
      ST_REUSE  = 3'd0,
      ST_BUMP   = 3'd1,
      ST_NEWBLK = 3'd2,
      ST_OOM    = 3'd3,
      ST_FREED  = 3'd4
   } status_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ITEM_BYTES      = 1'b0,
      CSR_ITEMS_PER_BLOCK = 1'b1
   } csr_reg_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_IDX_MUL,
      S_IDX_ADD,
      S_OFF_MUL,
      S_RSP
   } seq_state_type;

   typedef struct packed {
      logic             valid;
      logic [IDX_W-1:0] index;
   } link_entry_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      link_entry_type   data;
   } link_wr_type;

   typedef struct packed {
      logic [IDX_W-1:0]   a;
      logic [BYTES_W-1:0] b;
   } mul_req_type;

endpackage

/* rtl/fsipa_link_ram.sv */
`timescale 1ns / 1ps

module fsipa_link_ram #(
   parameter int DEPTH = 16384,
   parameter int AW = 14
) (
   input  logic                     clock,
   input  fsipa_pkg::link_wr_type   wr,
   input  logic [fsipa_pkg::IDX_W-1:0] rd_addr,
   output fsipa_pkg::link_entry_type rd_data
);
   import fsipa_pkg::*;

   link_entry_type mem [DEPTH];
   link_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr[AW-1:0]] <= wr.data;
      end
      rd_data_ff <= mem[rd_addr[AW-1:0]];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/fsipa_mul.sv */
`timescale 1ns / 1ps

module fsipa_mul (
   input  logic                         clock,
   input  fsipa_pkg::mul_req_type       req,
   output logic [fsipa_pkg::PROD_W-1:0] product
);
   import fsipa_pkg::*;

   logic [PROD_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= PROD_W'(req.a) * PROD_W'(req.b);
   end

   assign product = prod_ff;

endmodule

/* rtl/fsipa_ctrl.sv */
`timescale 1ns / 1ps

module fsipa_ctrl #(
   parameter int NUM_POOLS = fsipa_pkg::NUM_POOLS_DEF,
   parameter int NUM_BLOCKS = fsipa_pkg::NUM_BLOCKS_DEF,
   parameter int MAX_ITEMS_PER_BLOCK = fsipa_pkg::MAX_ITEMS_DEF,
   parameter int BUMP_W = $clog2(fsipa_pkg::MAX_ITEMS_DEF + 1)
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic                            req_mode,
   input  logic [fsipa_pkg::POOL_ID_W-1:0] req_pool_id,
   input  logic [fsipa_pkg::IDX_W-1:0]     req_item_index,
   input  logic [fsipa_pkg::BYTES_W-1:0]   eff_bytes,
   input  logic [BUMP_W-1:0]               eff_ipb,
   output fsipa_pkg::link_wr_type          link_wr,
   output logic [fsipa_pkg::IDX_W-1:0]     link_rd_addr,
   input  fsipa_pkg::link_entry_type       link_rd_data,
   output fsipa_pkg::mul_req_type          mul_req,
   input  logic [fsipa_pkg::PROD_W-1:0]    mul_prod,
   output logic                            rsp_strobe,
   output logic [fsipa_pkg::STATUS_W-1:0]  rsp_status,
   output logic [fsipa_pkg::IDX_W-1:0]     rsp_out_index,
   output logic [fsipa_pkg::OFF_W-1:0]     rsp_byte_offset,
   output logic                            rsp_bad_index
);
   import fsipa_pkg::*;

   localparam int POOL_W = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
   localparam int SEL_W = (POOL_W > POOL_ID_W) ? POOL_W : POOL_ID_W;
   localparam int BLK_W = $clog2(NUM_BLOCKS + 1);
   localparam int TOTAL_ITEMS = NUM_BLOCKS * MAX_ITEMS_PER_BLOCK;
   localparam int NEXT_RESET = (NUM_POOLS < NUM_BLOCKS) ? NUM_POOLS : NUM_BLOCKS;

   seq_state_type      state_ff, state_in;
   logic               mode_ff, mode_in;
   logic [POOL_ID_W-1:0] pid_ff, pid_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   status_type         status_ff, status_in;
   logic               bad_ff, bad_in;
   logic [BLK_W-1:0]   blk_ff, blk_in;
   logic [IDX_W-1:0]   add_ff, add_in;
   logic [IDX_W-1:0]   item_ff, item_in;

   link_entry_type     head_ff [NUM_POOLS];
   link_entry_type     head_in [NUM_POOLS];
   logic [BLK_W-1:0]   block_ff [NUM_POOLS];
   logic [BLK_W-1:0]   block_in [NUM_POOLS];
   logic [BUMP_W-1:0]  bump_ff [NUM_POOLS];
   logic [BUMP_W-1:0]  bump_in [NUM_POOLS];
   logic [BLK_W-1:0]   next_blk_ff, next_blk_in;

   logic [SEL_W-1:0]   pid_ext, req_ext;
   logic [POOL_W-1:0]  sel, req_sel;
   logic               pool_ok, req_ok, idx_ok;

   assign pid_ext = SEL_W'(pid_ff);
   assign req_ext = SEL_W'(req_pool_id);
   assign sel = pid_ext[POOL_W-1:0];
   assign req_sel = req_ext[POOL_W-1:0];
   assign pool_ok = 32'(pid_ff) < NUM_POOLS;
   assign req_ok = 32'(req_pool_id) < NUM_POOLS;
   assign idx_ok = 32'(idx_ff) < TOTAL_ITEMS;

   assign link_rd_addr = req_ok ? head_ff[req_sel].index : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         next_blk_ff <= BLK_W'(NEXT_RESET);
         for (int p = 0; p < NUM_POOLS; p++) begin
            head_ff[p] <= '0;
            block_ff[p] <= BLK_W'((p < NUM_BLOCKS) ? p : NUM_BLOCKS);
            bump_ff[p] <= '0;
         end
      end else begin
         state_ff <= state_in;
         next_blk_ff <= next_blk_in;
         head_ff <= head_in;
         block_ff <= block_in;
         bump_ff <= bump_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff <= mode_in;
      pid_ff <= pid_in;
      idx_ff <= idx_in;
      status_ff <= status_in;
      bad_ff <= bad_in;
      blk_ff <= blk_in;
      add_ff <= add_in;
      item_ff <= item_in;
   end

   always_comb begin
      state_in = state_ff;
      mode_in = mode_ff;
      pid_in = pid_ff;
      idx_in = idx_ff;
      status_in = status_ff;
      bad_in = bad_ff;
      blk_in = blk_ff;
      add_in = add_ff;
      item_in = item_ff;
      head_in = head_ff;
      block_in = block_ff;
      bump_in = bump_ff;
      next_blk_in = next_blk_ff;
      link_wr = '0;
      mul_req = '0;
      busy = 1'b1;
      rsp_strobe = 1'b0;

      case (state_ff)
         S_IDLE: begin
            busy = 1'b0;
            if (start) begin
               mode_in = req_mode;
               pid_in = req_pool_id;
               idx_in = req_item_index;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            bad_in = 1'b0;
            blk_in = '0;
            add_in = '0;
            state_in = S_IDX_MUL;
            if (!mode_ff) begin
               if (!pool_ok) begin
                  status_in = ST_OOM;
               end else if (head_ff[sel].valid) begin
                  status_in = ST_REUSE;
                  head_in[sel] = link_rd_data;
                  add_in = head_ff[sel].index;
               end else if ((32'(block_ff[sel]) < NUM_BLOCKS) &&
                            (bump_ff[sel] < eff_ipb)) begin
                  status_in = ST_BUMP;
                  blk_in = block_ff[sel];
                  add_in = IDX_W'(bump_ff[sel]);
                  bump_in[sel] = bump_ff[sel] + 1'b1;
               end else if (32'(next_blk_ff) < NUM_BLOCKS) begin
                  status_in = ST_NEWBLK;
                  blk_in = next_blk_ff;
                  block_in[sel] = next_blk_ff;
                  next_blk_in = next_blk_ff + 1'b1;
                  bump_in[sel] = BUMP_W'(1);
               end else begin
                  status_in = ST_OOM;
               end
            end else begin
               status_in = ST_FREED;
               if (!pool_ok || !idx_ok) begin
                  bad_in = 1'b1;
               end else begin
                  link_wr.en = 1'b1;
                  link_wr.addr = idx_ff;
                  link_wr.data = head_ff[sel];
                  head_in[sel].valid = 1'b1;
                  head_in[sel].index = idx_ff;
               end
            end
         end
         S_IDX_MUL: begin
            mul_req.a = IDX_W'(blk_ff);
            mul_req.b = BYTES_W'(MAX_ITEMS_PER_BLOCK);
            state_in = S_IDX_ADD;
         end
         S_IDX_ADD: begin
            item_in = mul_prod[IDX_W-1:0] + add_ff;
            state_in = S_OFF_MUL;
         end
         S_OFF_MUL: begin
            mul_req.a = item_ff;
            mul_req.b = eff_bytes;
            state_in = S_RSP;
         end
         S_RSP: begin
            busy = 1'b0;
            rsp_strobe = 1'b1;
            state_in = S_IDLE;
            if (start) begin
               mode_in = req_mode;
               pid_in = req_pool_id;
               idx_in = req_item_index;
               state_in = S_EXEC;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_status = status_ff;
   assign rsp_out_index = item_ff;
   assign rsp_byte_offset = mul_prod[OFF_W-1:0];
   assign rsp_bad_index = bad_ff;

endmodule

/* rtl/fixed_size_item_pool_allocator_top.sv */
// rsp_strobe is high in S_RSP, reached via S_EXEC, S_IDX_MUL, S_IDX_ADD and S_OFF_MUL.
// Busy until the result is shown: the sequencer walks a link read, then
//   two passes through one shared 14x17 multiplier (index, then byte offset).
// A new transaction may be accepted in the cycle its predecessor's result is shown.
// Reset is synchronous: pool heads and bump counts cleared, link memory left unwritten.
// The receiver cannot stall: each result is shown for exactly one cycle.
`timescale 1ns / 1ps

module fixed_size_item_pool_allocator_top #(
   parameter int NUM_POOLS = fsipa_pkg::NUM_POOLS_DEF,
   parameter int NUM_BLOCKS = fsipa_pkg::NUM_BLOCKS_DEF,
   parameter int MAX_ITEMS_PER_BLOCK = fsipa_pkg::MAX_ITEMS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_mode,
   input  logic [fsipa_pkg::POOL_ID_W-1:0]   req_pool_id,
   input  logic [fsipa_pkg::IDX_W-1:0]       req_item_index,
   output logic                              rsp_strobe,
   output logic [fsipa_pkg::STATUS_W-1:0]    rsp_status,
   output logic [fsipa_pkg::IDX_W-1:0]       rsp_out_index,
   output logic [fsipa_pkg::OFF_W-1:0]       rsp_byte_offset,
   output logic                              rsp_bad_index,
   input  logic                              csr_write_en,
   input  logic [fsipa_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [fsipa_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import fsipa_pkg::*;

   localparam int BUMP_W = $clog2(MAX_ITEMS_PER_BLOCK + 1);
   localparam int TOTAL_ITEMS = NUM_BLOCKS * MAX_ITEMS_PER_BLOCK;
   localparam int LINK_DEPTH = (TOTAL_ITEMS < (1 << IDX_W)) ? TOTAL_ITEMS : (1 << IDX_W);
   localparam int LINK_AW = $clog2(LINK_DEPTH);
   localparam int IPB_RESET =
      (RESET_IPB < MAX_ITEMS_PER_BLOCK) ? RESET_IPB : MAX_ITEMS_PER_BLOCK;

   logic [BYTES_W-1:0] eff_bytes_ff, eff_bytes_in;
   logic [BUMP_W-1:0]  eff_ipb_ff, eff_ipb_in;
   logic [BYTES_W-1:0] bytes_masked;
   logic [IPB_W-1:0]   ipb_raw;

   link_wr_type        link_wr;
   logic [IDX_W-1:0]   link_rd_addr;
   link_entry_type     link_rd_data;
   mul_req_type        mul_req;
   logic [PROD_W-1:0]  mul_prod;

   assign bytes_masked = {csr_wdata[BYTES_W-1:4], 4'b0000};
   assign ipb_raw = csr_wdata[IPB_W-1:0];

   // registers hold the clamped values
   always_comb begin
      eff_bytes_in = eff_bytes_ff;
      eff_ipb_in = eff_ipb_ff;
      if (csr_write_en) begin
         case (csr_reg_type'(csr_index))
            CSR_ITEM_BYTES: begin
               if (32'(bytes_masked) < MIN_ITEM_BYTES) begin
                  eff_bytes_in = BYTES_W'(MIN_ITEM_BYTES);
               end else if (32'(bytes_masked) > MAX_ITEM_BYTES) begin
                  eff_bytes_in = BYTES_W'(MAX_ITEM_BYTES);
               end else begin
                  eff_bytes_in = bytes_masked;
               end
            end
            CSR_ITEMS_PER_BLOCK: begin
               if (ipb_raw == '0) begin
                  eff_ipb_in = BUMP_W'(1);
               end else if (32'(ipb_raw) > MAX_ITEMS_PER_BLOCK) begin
                  eff_ipb_in = BUMP_W'(MAX_ITEMS_PER_BLOCK);
               end else begin
                  eff_ipb_in = BUMP_W'(ipb_raw);
               end
            end
            default: begin
               eff_bytes_in = eff_bytes_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eff_bytes_ff <= BYTES_W'(RESET_ITEM_BYTES);
         eff_ipb_ff <= BUMP_W'(IPB_RESET);
      end else begin
         eff_bytes_ff <= eff_bytes_in;
         eff_ipb_ff <= eff_ipb_in;
      end
   end

   fsipa_ctrl #(
      .NUM_POOLS(NUM_POOLS),
      .NUM_BLOCKS(NUM_BLOCKS),
      .MAX_ITEMS_PER_BLOCK(MAX_ITEMS_PER_BLOCK),
      .BUMP_W(BUMP_W)
   ) u_ctrl (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_mode(req_mode),
      .req_pool_id(req_pool_id),
      .req_item_index(req_item_index),
      .eff_bytes(eff_bytes_ff),
      .eff_ipb(eff_ipb_ff),
      .link_wr(link_wr),
      .link_rd_addr(link_rd_addr),
      .link_rd_data(link_rd_data),
      .mul_req(mul_req),
      .mul_prod(mul_prod),
      .rsp_strobe(rsp_strobe),
      .rsp_status(rsp_status),
      .rsp_out_index(rsp_out_index),
      .rsp_byte_offset(rsp_byte_offset),
      .rsp_bad_index(rsp_bad_index)
   );

   fsipa_link_ram #(
      .DEPTH(LINK_DEPTH),
      .AW(LINK_AW)
   ) u_link_ram (
      .clock(clock),
      .wr(link_wr),
      .rd_addr(link_rd_addr),
      .rd_data(link_rd_data)
   );

   fsipa_mul u_mul (
      .clock(clock),
      .req(mul_req),
      .product(mul_prod)
   );

endmodule
